// ----- rtl/core/tbgp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tbgp_pkg;

    localparam int COORD_BITS     = 20;
    localparam int BOX_BITS       = 3 * COORD_BITS;
    localparam int DIV_FIELD_BITS = 5;
    localparam int DIVS_BITS      = 3 * DIV_FIELD_BITS;
    localparam int ID_BITS        = 13;
    localparam int NUM_BITS       = COORD_BITS + DIV_FIELD_BITS;
    localparam int PROD_BITS      = 2 * DIV_FIELD_BITS;

    localparam int DEFAULT_MAX_DIVISIONS = 16;

    // Must stay a power of two so the queue pointers wrap naturally.
    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_ADDR_BITS = 6;
    localparam int REG_IDX_LSB   = 3;
    localparam int REG_IDX_BITS  = CFG_ADDR_BITS - REG_IDX_LSB;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_FINE_LOW  = 3'd0,
        REG_FINE_HIGH = 3'd1,
        REG_BASE_LOW  = 3'd2,
        REG_BASE_HIGH = 3'd3,
        REG_FINE_DIV  = 3'd4,
        REG_BASE_DIV  = 3'd5
    } t_reg_idx;

    localparam logic [BOX_BITS-1:0] FINE_LOW_RESET =
        {COORD_BITS'(256), COORD_BITS'(256), COORD_BITS'(256)};
    localparam logic [BOX_BITS-1:0] FINE_HIGH_RESET =
        {COORD_BITS'(768), COORD_BITS'(768), COORD_BITS'(768)};
    localparam logic [BOX_BITS-1:0] BASE_LOW_RESET = '0;
    localparam logic [BOX_BITS-1:0] BASE_HIGH_RESET =
        {COORD_BITS'(1024), COORD_BITS'(1024), COORD_BITS'(1024)};
    localparam logic [DIVS_BITS-1:0] DIVS_RESET =
        {DIV_FIELD_BITS'(2), DIV_FIELD_BITS'(2), DIV_FIELD_BITS'(2)};

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
    } t_point;

    typedef struct packed {
        logic [ID_BITS-1:0] partition_id;
        logic               in_fine_box;
        logic               out_of_range;
    } t_result;

    typedef struct packed {
        logic [BOX_BITS-1:0]  fine_low;
        logic [BOX_BITS-1:0]  fine_high;
        logic [BOX_BITS-1:0]  base_low;
        logic [BOX_BITS-1:0]  base_high;
        logic [DIVS_BITS-1:0] fine_div;
        logic [DIVS_BITS-1:0] base_div;
    } t_cfg;

    // One axis of classified work: quotient of num by den, clamped to n-1.
    typedef struct packed {
        logic [NUM_BITS-1:0]       num;
        logic [COORD_BITS-1:0]     den;
        logic [DIV_FIELD_BITS-1:0] n;
        logic                      force_max;
    } t_axis_job;

    typedef struct packed {
        t_axis_job [2:0]           axis;
        logic [DIV_FIELD_BITS-1:0] n0;
        logic [PROD_BITS-1:0]      n01;
        logic [ID_BITS-1:0]        offset;
        logic                      in_fine_box;
        logic                      flag;
    } t_job;

endpackage

`default_nettype wire

// ----- rtl/core/tbgp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tbgp_front #(
    parameter int MAX_DIVISIONS = tbgp_pkg::DEFAULT_MAX_DIVISIONS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire tbgp_pkg::t_cfg   i_cfg,
    input  wire logic             i_start,
    input  wire tbgp_pkg::t_point i_point,
    output logic                  o_busy,
    output logic                  o_push,
    output tbgp_pkg::t_job        o_job,
    input  wire logic             i_full
);
    import tbgp_pkg::*;

    localparam logic [DIV_FIELD_BITS-1:0] MAX_LIM = DIV_FIELD_BITS'(MAX_DIVISIONS);

    function automatic logic [DIV_FIELD_BITS-1:0] decode_div(
        input logic [DIVS_BITS-1:0] f,
        input int unsigned          axis
    );
        logic [DIV_FIELD_BITS-1:0] raw;
        raw = f[axis*DIV_FIELD_BITS +: DIV_FIELD_BITS];
        if (raw == '0) begin
            return DIV_FIELD_BITS'(1);
        end else if (raw > MAX_LIM) begin
            return MAX_LIM;
        end
        return raw;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] coord(
        input logic [BOX_BITS-1:0] box,
        input int unsigned         axis
    );
        return $signed(box[axis*COORD_BITS +: COORD_BITS]);
    endfunction

    logic                              w_accept;
    logic                              w_adv;
    logic signed [COORD_BITS-1:0]      w_p [3];
    logic                              w_inside;
    logic [DIV_FIELD_BITS-1:0]         w_n [3];
    logic [PROD_BITS-1:0]              w_nf01;
    logic [DIV_FIELD_BITS-1:0]         w_nfz;
    t_job                              w_job;

    logic                              r_a_valid;
    logic signed [COORD_BITS-1:0]      r_a_p [3];
    logic                              r_a_inside;
    logic [BOX_BITS-1:0]               r_a_lo;
    logic [BOX_BITS-1:0]               r_a_hi;
    logic [DIV_FIELD_BITS-1:0]         r_a_n [3];
    logic [PROD_BITS-1:0]              r_a_nf01;
    logic [DIV_FIELD_BITS-1:0]         r_a_nfz;
    logic                              r_b_valid;
    t_job                              r_b_job;

    assign w_adv    = !r_b_valid || !i_full;
    assign o_busy   = !i_rst_n || (r_a_valid && !w_adv);
    assign w_accept = i_start && !o_busy;
    assign o_push   = r_b_valid && !i_full;
    assign o_job    = r_b_job;

    assign w_p[0] = i_point.point_x;
    assign w_p[1] = i_point.point_y;
    assign w_p[2] = i_point.point_z;

    // Classify against the fine box and pick the box that will be used.
    always_comb begin
        logic [2:0] in_fine;
        for (int a = 0; a < 3; a++) begin
            in_fine[a] = (w_p[a] >= coord(i_cfg.fine_low, a))
                      && (w_p[a] <= coord(i_cfg.fine_high, a));
        end
        w_inside = &in_fine;
        for (int a = 0; a < 3; a++) begin
            w_n[a] = w_inside ? decode_div(i_cfg.fine_div, a)
                              : decode_div(i_cfg.base_div, a);
        end
        w_nf01 = PROD_BITS'(decode_div(i_cfg.fine_div, 0))
               * PROD_BITS'(decode_div(i_cfg.fine_div, 1));
        w_nfz  = decode_div(i_cfg.fine_div, 2);
    end

    // Per-axis range checks and the scaled numerator for the divider.
    always_comb begin
        logic signed [COORD_BITS-1:0] lo;
        logic signed [COORD_BITS-1:0] hi;
        logic signed [COORD_BITS:0]   wid;
        logic signed [COORD_BITS:0]   dif;
        logic                         below;
        logic                         above;
        logic                         wpos;
        logic                         forced;
        logic [2:0]                   any_forced;
        logic [DIVS_BITS-1:0]         nf;
        w_job = '0;
        for (int a = 0; a < 3; a++) begin
            lo     = coord(r_a_lo, a);
            hi     = coord(r_a_hi, a);
            wid    = (COORD_BITS+1)'(hi) - (COORD_BITS+1)'(lo);
            dif    = (COORD_BITS+1)'(r_a_p[a]) - (COORD_BITS+1)'(lo);
            below  = r_a_p[a] < lo;
            above  = r_a_p[a] > hi;
            wpos   = wid > 0;
            forced = !wpos || below || above;
            any_forced[a] = forced;
            w_job.axis[a].den       = forced ? COORD_BITS'(1) : wid[COORD_BITS-1:0];
            w_job.axis[a].num       = (forced ? NUM_BITS'(0) : NUM_BITS'(dif[COORD_BITS-1:0]))
                                    * NUM_BITS'(r_a_n[a]);
            w_job.axis[a].n         = r_a_n[a];
            w_job.axis[a].force_max = wpos && !below && above;
        end
        nf                = DIVS_BITS'(r_a_nf01) * DIVS_BITS'(r_a_nfz);
        w_job.n0          = r_a_n[0];
        w_job.n01         = PROD_BITS'(r_a_n[0]) * PROD_BITS'(r_a_n[1]);
        w_job.offset      = r_a_inside ? ID_BITS'(0) : nf[ID_BITS-1:0];
        w_job.in_fine_box = r_a_inside;
        w_job.flag        = |any_forced;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_a_valid <= w_accept;
            end else if (w_accept) begin
                r_a_valid <= 1'b1;
            end
            if (w_adv) begin
                r_b_valid <= r_a_valid;
            end
        end
        if (w_accept) begin
            r_a_p      <= w_p;
            r_a_inside <= w_inside;
            r_a_lo     <= w_inside ? i_cfg.fine_low : i_cfg.base_low;
            r_a_hi     <= w_inside ? i_cfg.fine_high : i_cfg.base_high;
            r_a_n      <= w_n;
            r_a_nf01   <= w_nf01;
            r_a_nfz    <= w_nfz;
        end
        if (w_adv) begin
            r_b_job <= w_job;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/tbgp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tbgp_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire tbgp_pkg::t_job i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output tbgp_pkg::t_job      o_data
);
    import tbgp_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    t_job                r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                w_do_push;
    logic                w_do_pop;

    assign o_full    = r_count == CNT_BITS'(QUEUE_DEPTH);
    assign o_valid   = r_count != '0;
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_BITS'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_BITS'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CNT_BITS'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CNT_BITS'(1);
            end
        end
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/tbgp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tbgp_back #(
    parameter int MAX_DIVISIONS = tbgp_pkg::DEFAULT_MAX_DIVISIONS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire tbgp_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_valid,
    output tbgp_pkg::t_result   o_result
);
    import tbgp_pkg::*;

    // The quotient never exceeds the division count, so this many bits suffice.
    localparam int STAGES = $clog2(MAX_DIVISIONS + 1);

    typedef struct packed {
        logic [NUM_BITS-1:0]       rem;
        logic [COORD_BITS-1:0]     den;
        logic [DIV_FIELD_BITS-1:0] n;
        logic                      force_max;
        logic [DIV_FIELD_BITS-1:0] q;
    } t_lane;

    typedef struct packed {
        t_lane [2:0]               lane;
        logic [DIV_FIELD_BITS-1:0] n0;
        logic [PROD_BITS-1:0]      n01;
        logic [ID_BITS-1:0]        offset;
        logic                      in_fine_box;
        logic                      flag;
    } t_stage;

    function automatic t_stage to_stage(input t_job j);
        t_stage s;
        for (int a = 0; a < 3; a++) begin
            s.lane[a].rem       = j.axis[a].num;
            s.lane[a].den       = j.axis[a].den;
            s.lane[a].n         = j.axis[a].n;
            s.lane[a].force_max = j.axis[a].force_max;
            s.lane[a].q         = '0;
        end
        s.n0          = j.n0;
        s.n01         = j.n01;
        s.offset      = j.offset;
        s.in_fine_box = j.in_fine_box;
        s.flag        = j.flag;
        return s;
    endfunction

    // One restoring step: try the divisor shifted to this quotient bit.
    function automatic t_lane div_step(input t_lane l, input int unsigned bit_pos);
        t_lane               r;
        logic [NUM_BITS-1:0] trial;
        r     = l;
        trial = NUM_BITS'(l.den) << bit_pos;
        if (l.rem >= trial) begin
            r.rem        = l.rem - trial;
            r.q[bit_pos] = 1'b1;
        end
        return r;
    endfunction

    t_stage  w_in    [STAGES];
    t_stage  w_out   [STAGES];
    t_stage  r_stage [STAGES];
    logic    r_valid [STAGES];
    logic    r_out_valid;
    t_result r_result;

    assign o_pop    = i_valid;
    assign w_in[0]  = to_stage(i_job);

    for (genvar j = 0; j < STAGES; j++) begin : g_div
        if (j > 0) begin : g_link
            assign w_in[j] = r_stage[j-1];
        end

        always_comb begin
            w_out[j] = w_in[j];
            for (int a = 0; a < 3; a++) begin
                w_out[j].lane[a] = div_step(w_in[j].lane[a], STAGES - 1 - j);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else begin
                r_valid[j] <= (j == 0) ? i_valid : r_valid[(j > 0) ? j - 1 : 0];
            end
            r_stage[j] <= w_out[j];
        end
    end

    always_comb begin
        logic [DIV_FIELD_BITS-1:0]           idx [3];
        logic [PROD_BITS-1:0]                term_y;
        logic [PROD_BITS+DIV_FIELD_BITS-1:0] term_z;
        t_stage                              s;
        s = r_stage[STAGES-1];
        for (int a = 0; a < 3; a++) begin
            idx[a] = (s.lane[a].force_max || (s.lane[a].q >= s.lane[a].n))
                   ? s.lane[a].n - DIV_FIELD_BITS'(1) : s.lane[a].q;
        end
        term_y = PROD_BITS'(idx[1]) * PROD_BITS'(s.n0);
        term_z = (PROD_BITS+DIV_FIELD_BITS)'(idx[2]) * (PROD_BITS+DIV_FIELD_BITS)'(s.n01);
        r_result.partition_id = ID_BITS'(idx[0]) + ID_BITS'(term_y)
                              + term_z[ID_BITS-1:0] + s.offset;
        r_result.in_fine_box  = s.in_fine_box;
        r_result.out_of_range = s.flag;
    end

    t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_valid[STAGES-1];
        end
        r_out <= r_result;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

// ----- rtl/core/two_box_grid_partition_index_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Maps one cell centroid (signed Q10.10 x, y, z) to a partition number, one point
// per clock. A point is taken whenever start is high and busy is low; busy is high
// only during reset, because the result side can never be held off. Each result
// appears on o_result for exactly one cycle, marked by o_valid, after it passes
// through these registered steps: two front stages classify the point and scale
// it, a two-entry queue hands it over, and a pipelined restoring divider per axis
// resolves one quotient bit per stage before the final index sum is registered.
// Results leave in the order the points came in. Box corners and division counts
// are written through the register port at byte addresses 0, 8, ..., 40 and should
// only be changed while no point is in flight.
module two_box_grid_partition_index_unit #(
    parameter int MAX_DIVISIONS = tbgp_pkg::DEFAULT_MAX_DIVISIONS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire tbgp_pkg::t_point                    i_point,
    output logic                                     o_valid,
    output tbgp_pkg::t_result                        o_result,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [tbgp_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  wire logic [tbgp_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [tbgp_pkg::CFG_DATA_BITS-1:0]       prdata,
    output logic                                     pready
);
    import tbgp_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;
    logic     w_push;
    logic     w_full;
    t_job     w_front_job;
    logic     w_q_valid;
    t_job     w_q_job;
    logic     w_pop;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[CFG_ADDR_BITS-1:REG_IDX_LSB]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fine_low  <= FINE_LOW_RESET;
            r_cfg.fine_high <= FINE_HIGH_RESET;
            r_cfg.base_low  <= BASE_LOW_RESET;
            r_cfg.base_high <= BASE_HIGH_RESET;
            r_cfg.fine_div  <= DIVS_RESET;
            r_cfg.base_div  <= DIVS_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_FINE_LOW:  r_cfg.fine_low  <= pwdata[BOX_BITS-1:0];
                REG_FINE_HIGH: r_cfg.fine_high <= pwdata[BOX_BITS-1:0];
                REG_BASE_LOW:  r_cfg.base_low  <= pwdata[BOX_BITS-1:0];
                REG_BASE_HIGH: r_cfg.base_high <= pwdata[BOX_BITS-1:0];
                REG_FINE_DIV:  r_cfg.fine_div  <= pwdata[DIVS_BITS-1:0];
                REG_BASE_DIV:  r_cfg.base_div  <= pwdata[DIVS_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_FINE_LOW:  prdata = CFG_DATA_BITS'(r_cfg.fine_low);
            REG_FINE_HIGH: prdata = CFG_DATA_BITS'(r_cfg.fine_high);
            REG_BASE_LOW:  prdata = CFG_DATA_BITS'(r_cfg.base_low);
            REG_BASE_HIGH: prdata = CFG_DATA_BITS'(r_cfg.base_high);
            REG_FINE_DIV:  prdata = CFG_DATA_BITS'(r_cfg.fine_div);
            REG_BASE_DIV:  prdata = CFG_DATA_BITS'(r_cfg.base_div);
            default:       prdata = '0;
        endcase
    end

    tbgp_front #(
        .MAX_DIVISIONS(MAX_DIVISIONS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_start (start),
        .i_point (i_point),
        .o_busy  (busy),
        .o_push  (w_push),
        .o_job   (w_front_job),
        .i_full  (w_full)
    );

    tbgp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_job)
    );

    tbgp_back #(
        .MAX_DIVISIONS(MAX_DIVISIONS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_job    (w_q_job),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// ----- rtl/core/tbgp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tbgp_checker #(
    parameter int MAX_DIVISIONS = tbgp_pkg::DEFAULT_MAX_DIVISIONS
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid
);
    // Two front stages, the queue hop, one stage per quotient bit, the output register.
    localparam int LATENCY = $clog2(MAX_DIVISIONS + 1) + 4;

    // Every accepted transaction yields its result after the fixed latency.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("accepted transaction produced no result on time");

    // No result appears without a transaction accepted the same latency earlier.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching transaction");

    // The back end drains every cycle, so the front never has to stall.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised outside reset");

endmodule

bind two_box_grid_partition_index_unit tbgp_checker #(
    .MAX_DIVISIONS(MAX_DIVISIONS)
) u_tbgp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);

`default_nettype wire
